[src/assert_macros.svh]
// Assertion macros shared by the tile cache slot manager modules.
// Define NO_ASSERTIONS to compile them away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_IMPL(label, clk, rst_n, prop, msg)
`define ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

[src/tcsm_pkg.sv]
`timescale 1ns / 1ps
// Package for the tile cache slot manager: sizes, codes, beat types and
// controller/datapath interface structs. No dependencies.
package tcsm_pkg;
    localparam int CacheSlots    = 16;
    localparam int MaxFrameTiles = 16;
    localparam int SlotW  = $clog2(CacheSlots);
    localparam int TileW  = $clog2(MaxFrameTiles);
    localparam int CountW = $clog2(MaxFrameTiles + 1);
    localparam int ScanW  = $clog2(CacheSlots + 1);

    localparam logic [1:0] OP_TILE = 2'd0;
    localparam logic [1:0] OP_DONE = 2'd1;
    localparam logic [1:0] OP_FAIL = 2'd2;
    localparam logic [1:0] OP_RSVD = 2'd3;

    localparam logic [2:0] ST_OUTSIDE = 3'd0;
    localparam logic [2:0] ST_HIT     = 3'd1;
    localparam logic [2:0] ST_SHARED  = 3'd2;
    localparam logic [2:0] ST_NEW     = 3'd3;
    localparam logic [2:0] ST_NOSLOT  = 3'd4;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [21:0]        tile_x;
        logic signed [23:0] tile_y;
        logic [4:0]         zoom_level;
        logic [3:0]         done_slot;
        logic               last_of_frame;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  slot_index;
        logic [21:0] job_x;
        logic [21:0] job_y;
        logic        last_result;
    } t_out_beat;

    // controller -> datapath
    typedef struct packed {
        logic store_tile;   // append input tile to list, latch zoom
        logic apply_done;   // apply completion beat to slot flags
        logic load_tile;    // latch list entry tile_idx for classification
        logic clr_jobs;     // empty job list
        logic clr_tiles;    // empty tile list
        logic scan_hit;     // step hit scan over slots
        logic scan_job;     // step job list scan
        logic scan_vic;     // step victim scan (slot x tile)
        logic take_vic;     // mark victim busy and log job
        logic [TileW-1:0] tile_idx;
        logic [SlotW-1:0] slot_idx;
        logic [TileW-1:0] aux_idx;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic             outside;
        logic             hit;
        logic             job_match;
        logic             slot_busy;
        logic             need_match;
        logic [CountW-1:0] req_count;
        logic [CountW-1:0] job_count;
    } t_stat;
endpackage

[src/tcsm_datapath.sv]
`timescale 1ns / 1ps
// Datapath: tile list, slot tags and flags, frame job list and compare logic.
// Depends on tcsm_pkg.
`include "assert_macros.svh"
module tcsm_datapath import tcsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_beat  i_beat,
    input  t_cmd      i_cmd,
    output t_stat     o_stat,
    output logic [21:0] o_cur_x,
    output logic [21:0] o_cur_y,
    output logic [3:0]  o_job_slot
);
    logic [21:0]        r_req_x [MaxFrameTiles];
    logic signed [23:0] r_req_y [MaxFrameTiles];
    logic [CountW-1:0]  r_req_cnt;
    logic [4:0]         r_zoom;
    logic [21:0]        r_tag_x [CacheSlots];
    logic [21:0]        r_tag_y [CacheSlots];
    logic [4:0]         r_tag_z [CacheSlots];
    logic [CacheSlots-1:0] r_valid, r_busy;
    logic [21:0]        r_job_x [MaxFrameTiles];
    logic [21:0]        r_job_y [MaxFrameTiles];
    logic [SlotW-1:0]   r_job_s [MaxFrameTiles];
    logic [CountW-1:0]  r_job_cnt;
    logic [21:0]        r_cx;
    logic signed [23:0] r_cy;

    logic [4:0]  zc;
    logic [23:0] rows;
    logic        slot_idx_ok;
    logic        hit_s, need_s;

    assign zc   = (r_zoom > 5'd22) ? 5'd22 : r_zoom;
    assign rows = 24'd1 << zc;
    assign slot_idx_ok = ({1'b0, i_beat.done_slot} < 5'(CacheSlots));

    // tag compare of the current tile against slot slot_idx
    assign hit_s = r_valid[i_cmd.slot_idx] && !r_cy[23]
        && r_tag_x[i_cmd.slot_idx] == r_cx
        && r_tag_y[i_cmd.slot_idx] == r_cy[21:0] && r_cy[22] == 1'b0
        && r_tag_z[i_cmd.slot_idx] == r_zoom;
    // tag compare of list tile aux_idx against slot slot_idx
    assign need_s = r_valid[i_cmd.slot_idx] && !r_req_y[i_cmd.aux_idx][23]
        && r_req_y[i_cmd.aux_idx][22] == 1'b0
        && r_tag_x[i_cmd.slot_idx] == r_req_x[i_cmd.aux_idx]
        && r_tag_y[i_cmd.slot_idx] == r_req_y[i_cmd.aux_idx][21:0]
        && r_tag_z[i_cmd.slot_idx] == r_zoom;

    assign o_stat.outside   = r_cy[23] || ($unsigned(r_cy) >= rows);
    assign o_stat.hit       = hit_s;
    assign o_stat.job_match = r_job_x[i_cmd.aux_idx] == r_cx
        && r_job_y[i_cmd.aux_idx] == r_cy[21:0];
    assign o_stat.slot_busy  = r_busy[i_cmd.slot_idx];
    assign o_stat.need_match = need_s;
    assign o_stat.req_count  = r_req_cnt;
    assign o_stat.job_count  = r_job_cnt;
    assign o_cur_x    = r_cx;
    assign o_cur_y    = r_cy[21:0];
    assign o_job_slot = 4'(r_job_s[i_cmd.aux_idx]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_cnt <= '0;
            r_job_cnt <= '0;
            r_valid   <= '0;
            r_busy    <= '0;
            for (int s = 0; s < CacheSlots; s++) begin
                r_tag_x[s] <= '0;
                r_tag_y[s] <= '0;
                r_tag_z[s] <= '0;
            end
        end else begin
            if (i_cmd.store_tile) begin
                r_zoom <= i_beat.zoom_level;
                if (r_req_cnt < CountW'(MaxFrameTiles)) begin
                    r_req_x[r_req_cnt[TileW-1:0]] <= i_beat.tile_x;
                    r_req_y[r_req_cnt[TileW-1:0]] <= i_beat.tile_y;
                    r_req_cnt <= r_req_cnt + 1'b1;
                end
            end
            if (i_cmd.apply_done && slot_idx_ok) begin
                if (i_beat.opcode == OP_DONE) begin
                    r_tag_x[SlotW'(i_beat.done_slot)] <= i_beat.tile_x;
                    r_tag_y[SlotW'(i_beat.done_slot)] <= i_beat.tile_y[21:0];
                    r_tag_z[SlotW'(i_beat.done_slot)] <= i_beat.zoom_level;
                    r_valid[SlotW'(i_beat.done_slot)] <= 1'b1;
                end else begin
                    r_valid[SlotW'(i_beat.done_slot)] <= 1'b0;
                end
                r_busy[SlotW'(i_beat.done_slot)] <= 1'b0;
            end
            if (i_cmd.load_tile) begin
                r_cx <= r_req_x[i_cmd.tile_idx];
                r_cy <= r_req_y[i_cmd.tile_idx];
            end
            if (i_cmd.take_vic) begin
                r_busy[i_cmd.slot_idx] <= 1'b1;
                if (r_job_cnt < CountW'(MaxFrameTiles)) begin
                    r_job_x[r_job_cnt[TileW-1:0]] <= r_cx;
                    r_job_y[r_job_cnt[TileW-1:0]] <= r_cy[21:0];
                    r_job_s[r_job_cnt[TileW-1:0]] <= i_cmd.slot_idx;
                    r_job_cnt <= r_job_cnt + 1'b1;
                end
            end
            if (i_cmd.clr_jobs)  r_job_cnt <= '0;
            if (i_cmd.clr_tiles) r_req_cnt <= '0;
        end
    end

    `ASSERT_IMPL(a_req_bound, i_clk, i_rst_n, r_req_cnt <= CountW'(MaxFrameTiles),
        "tile list count overflow")
    `ASSERT_IMPL(a_job_bound, i_clk, i_rst_n, r_job_cnt <= r_req_cnt || r_req_cnt == '0,
        "more jobs than tiles")
    `ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_cmd.take_vic && !i_cmd.apply_done,
        r_busy[$past(i_cmd.slot_idx)], "victim not marked busy")
endmodule

[src/tcsm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences the frame scan over slots and lists, and drives the
// output register. Depends on tcsm_pkg.
`include "assert_macros.svh"
module tcsm_ctrl import tcsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_beat,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data,
    output t_cmd      o_cmd,
    input  t_stat     i_stat,
    input  logic [21:0] i_cur_x,
    input  logic [21:0] i_cur_y,
    input  logic [3:0]  i_job_slot
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_LOAD = 3'd1;
    localparam logic [2:0] S_HIT  = 3'd2;
    localparam logic [2:0] S_JOB  = 3'd3;
    localparam logic [2:0] S_VIC  = 3'd4;
    localparam logic [2:0] S_EMIT = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [CountW-1:0] r_tile, n_tile;
    logic [ScanW-1:0]  r_slot, n_slot;
    logic [CountW-1:0] r_aux, n_aux;
    logic              r_vld, n_vld;
    t_out_beat         r_out, n_out;
    t_out_beat         r_res, n_res;
    logic              accept, last_tile;

    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE) || r_vld;
    assign o_valid = r_vld;
    assign o_data  = r_out;
    assign last_tile = (r_tile + 1'b1) == i_stat.req_count;

    always_comb begin
        n_state = r_state;
        n_tile  = r_tile;
        n_slot  = r_slot;
        n_aux   = r_aux;
        n_vld   = r_vld && i_stall;
        n_out   = r_out;
        n_res   = r_res;
        o_cmd   = '0;
        o_cmd.tile_idx = r_tile[TileW-1:0];
        o_cmd.slot_idx = r_slot[SlotW-1:0];
        o_cmd.aux_idx  = r_aux[TileW-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_beat.opcode == OP_TILE) begin
                        o_cmd.store_tile = 1'b1;
                        if (i_beat.last_of_frame) begin
                            n_tile = '0;
                            o_cmd.clr_jobs = 1'b1;
                            n_state = S_LOAD;
                        end
                    end else if (i_beat.opcode == OP_DONE || i_beat.opcode == OP_FAIL) begin
                        o_cmd.apply_done = 1'b1;
                    end
                end
            end
            S_LOAD: begin
                if (i_stat.req_count == '0) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.load_tile = 1'b1;
                    n_slot  = '0;
                    n_state = S_HIT;
                end
            end
            S_HIT: begin
                n_res = '0;
                n_res.last_result = last_tile;
                if (i_stat.outside) begin
                    n_res.status = ST_OUTSIDE;
                    n_state = S_EMIT;
                end else if (i_stat.hit) begin
                    n_res.status = ST_HIT;
                    n_res.slot_index = 4'(r_slot);
                    n_state = S_EMIT;
                end else if (r_slot == ScanW'(CacheSlots - 1)) begin
                    n_aux = '0;
                    n_state = S_JOB;
                end else begin
                    n_slot = r_slot + 1'b1;
                end
            end
            S_JOB: begin
                if (r_aux == i_stat.job_count) begin
                    n_slot = '0;
                    n_aux  = '0;
                    n_state = S_VIC;
                end else if (i_stat.job_match) begin
                    n_res.status = ST_SHARED;
                    n_res.slot_index = i_job_slot;
                    n_state = S_EMIT;
                end else begin
                    n_aux = r_aux + 1'b1;
                end
            end
            S_VIC: begin
                if (r_slot == ScanW'(CacheSlots)) begin
                    n_res.status = ST_NOSLOT;
                    n_state = S_EMIT;
                end else if (i_stat.slot_busy
                        || (r_aux != i_stat.req_count && i_stat.need_match)) begin
                    n_slot = r_slot + 1'b1;
                    n_aux  = '0;
                end else if (r_aux == i_stat.req_count) begin
                    o_cmd.take_vic = 1'b1;
                    n_res.status = ST_NEW;
                    n_res.slot_index = 4'(r_slot);
                    n_res.job_x = i_cur_x;
                    n_res.job_y = i_cur_y;
                    n_state = S_EMIT;
                end else begin
                    n_aux = r_aux + 1'b1;
                end
            end
            S_EMIT: begin
                // hold until the previous beat is taken
                if (!r_vld || !i_stall) begin
                    n_vld = 1'b1;
                    n_out = r_res;
                    if (r_res.last_result) begin
                        o_cmd.clr_tiles = 1'b1;
                        o_cmd.clr_jobs  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_tile  = r_tile + 1'b1;
                        n_state = S_LOAD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_vld   <= 1'b0;
            r_tile  <= '0;
            r_slot  <= '0;
            r_aux   <= '0;
        end else begin
            r_state <= n_state;
            r_vld   <= n_vld;
            r_tile  <= n_tile;
            r_slot  <= n_slot;
            r_aux   <= n_aux;
        end
        r_out <= n_out;
        r_res <= n_res;
    end

    `ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data),
        "stalled output beat changed")
    `ASSERT_IMPL(a_busy_stall, i_clk, i_rst_n, r_state == S_IDLE || o_stall,
        "input taken during frame scan")
    `ASSERT_IMPL(a_tile_bound, i_clk, i_rst_n,
        r_state == S_IDLE || r_tile < CountW'(MaxFrameTiles),
        "tile index out of range")
endmodule

[src/tile_cache_slot_manager_core.sv]
`timescale 1ns / 1ps
// Tile cache slot manager, top level: wires the controller to the datapath.
// Depends on tcsm_pkg, tcsm_ctrl and tcsm_datapath.
//
// Input channel (i_valid/o_stall, i_data): required tiles and fetch
// completions. Tiles are stored one per beat; the tile marked last starts
// the frame scan, and the block then stalls input until the final result
// beat of the frame has been taken. Input also stalls while a result waits.
// Output channel (o_valid/i_stall, o_data): one result beat per stored tile,
// in order, last_result on the final one. A stalled result holds, and the
// scan of the next tile waits in its emit step until the beat is taken.
// Completions and non-final tiles are handled in the idle state and start no scan.
// Per stored tile the scan loads the tile, runs the hit scan over the slots,
// then the frame job list, then the victim check, and emits; an outside tile
// or a hit goes straight to emit. The victim check, one slot against one frame
// tile per cycle, dominates.
// Reset (i_rst_n low, synchronous) clears all slot flags, tags and lists.
module tile_cache_slot_manager_core import tcsm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_beat o_data
);
    t_cmd        cmd;
    t_stat       stat;
    logic [21:0] cur_x, cur_y;
    logic [3:0]  job_slot;

    tcsm_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_beat(i_data),
        .o_valid, .i_stall, .o_data, .o_cmd(cmd), .i_stat(stat),
        .i_cur_x(cur_x), .i_cur_y(cur_y), .i_job_slot(job_slot)
    );

    tcsm_datapath u_dp (
        .i_clk, .i_rst_n, .i_beat(i_data), .i_cmd(cmd), .o_stat(stat),
        .o_cur_x(cur_x), .o_cur_y(cur_y), .o_job_slot(job_slot)
    );
endmodule

[test/tb_tile_cache_slot_manager_core.sv]
`timescale 1ns / 1ps
// Testbench for tile_cache_slot_manager_core: directed and random frames of
// tiles and fetch completions, checked beat by beat against a local model of
// the slot flags, tags and frame job list. Depends on tcsm_pkg and the RTL.
module tb_tile_cache_slot_manager_core;
    import tcsm_pkg::*;

    localparam int CycleLimit = 1000000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_stall;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_stall;
    t_out_beat o_data;

    tile_cache_slot_manager_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // model state
    logic [21:0]        list_x [MaxFrameTiles];
    logic signed [23:0] list_y [MaxFrameTiles];
    int                 list_n;
    logic [21:0]        tag_x [CacheSlots];
    logic [21:0]        tag_y [CacheSlots];
    logic [4:0]         tag_z [CacheSlots];
    bit                 slot_ok [CacheSlots];
    bit                 slot_bsy [CacheSlots];
    logic [21:0]        job_x [MaxFrameTiles];
    int                 job_y [MaxFrameTiles];
    int                 job_slot [MaxFrameTiles];
    int                 job_n;
    // tile each busy slot is fetching, used to build completions
    logic [21:0]        fetch_x [CacheSlots];
    logic [21:0]        fetch_y [CacheSlots];
    logic [4:0]         fetch_z [CacheSlots];

    t_out_beat exp_results [$];
    int        n_errors;
    int        n_cycles;
    int        stall_left;
    bit        stall_on;

    function automatic bit tag_hit(int s, logic [21:0] x, logic signed [23:0] y,
                                   logic [4:0] z);
        return slot_ok[s] && y >= 0 && y[23:22] == 2'b00 && tag_x[s] == x &&
               tag_y[s] == y[21:0] && tag_z[s] == z;
    endfunction

    function automatic int claim_victim(logic [4:0] z);
        bit needed;
        for (int s = 0; s < CacheSlots; s++) begin
            if (!slot_bsy[s]) begin
                needed = 0;
                for (int i = 0; i < list_n; i++)
                    if (tag_hit(s, list_x[i], list_y[i], z)) needed = 1;
                if (!needed) begin
                    slot_bsy[s] = 1;
                    return s;
                end
            end
        end
        return -1;
    endfunction

    function automatic t_out_beat classify_tile(logic [21:0] x,
                                                logic signed [23:0] y,
                                                logic [4:0] z);
        t_out_beat r;
        int rows;
        int yi;
        int v;
        r = '0;
        rows = 1 << ((z > 22) ? 22 : z);
        yi = y;
        if (yi < 0 || yi >= rows) begin
            r.status = ST_OUTSIDE;
            return r;
        end
        for (int s = 0; s < CacheSlots; s++) begin
            if (tag_hit(s, x, y, z)) begin
                r.status = ST_HIT;
                r.slot_index = s[3:0];
                return r;
            end
        end
        for (int j = 0; j < job_n; j++) begin
            if (job_x[j] == x && job_y[j] == yi) begin
                r.status = ST_SHARED;
                r.slot_index = job_slot[j][3:0];
                return r;
            end
        end
        v = claim_victim(z);
        if (v < 0) begin
            r.status = ST_NOSLOT;
            return r;
        end
        if (job_n < MaxFrameTiles) begin
            job_x[job_n] = x;
            job_y[job_n] = yi;
            job_slot[job_n] = v;
            job_n++;
        end
        fetch_x[v] = x;
        fetch_y[v] = y[21:0];
        fetch_z[v] = z;
        r.status = ST_NEW;
        r.slot_index = v[3:0];
        r.job_x = x;
        r.job_y = y[21:0];
        return r;
    endfunction

    function automatic void predict_beat(t_in_beat b);
        t_out_beat r;
        if (b.opcode == OP_DONE || b.opcode == OP_FAIL) begin
            if (b.opcode == OP_DONE) begin
                tag_x[b.done_slot] = b.tile_x;
                tag_y[b.done_slot] = b.tile_y[21:0];
                tag_z[b.done_slot] = b.zoom_level;
                slot_ok[b.done_slot] = 1;
            end else begin
                slot_ok[b.done_slot] = 0;
            end
            slot_bsy[b.done_slot] = 0;
            return;
        end
        if (b.opcode != OP_TILE) return;
        if (list_n < MaxFrameTiles) begin
            list_x[list_n] = b.tile_x;
            list_y[list_n] = b.tile_y;
            list_n++;
        end
        if (!b.last_of_frame) return;
        job_n = 0;
        for (int i = 0; i < list_n; i++) begin
            r = classify_tile(list_x[i], list_y[i], b.zoom_level);
            r.last_result = (i + 1 == list_n);
            exp_results.insert(exp_results.size(), r);
        end
        list_n = 0;
        job_n = 0;
    endfunction

    function automatic int gap_len();
        if ($urandom_range(0, 9) < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls: runs of free flow and of stall
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_on = ($urandom_range(0, 9) < 3);
            stall_left = stall_on ? gap_len() : $urandom_range(1, 30);
        end
        stall_left--;
        i_stall = stall_on;
    end

    always @(posedge i_clk) begin
        n_cycles++;
        if (n_cycles > CycleLimit) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (exp_results.size() == 0) begin
                $error("unexpected result beat %p", o_data);
                n_errors++;
            end else begin
                e = exp_results.pop_front();
                if (o_data.status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_data.status);
                    n_errors++;
                end
                if (o_data.slot_index !== e.slot_index) begin
                    $error("slot_index: expected %0d, got %0d", e.slot_index,
                           o_data.slot_index);
                    n_errors++;
                end
                if (o_data.job_x !== e.job_x) begin
                    $error("job_x: expected %0d, got %0d", e.job_x, o_data.job_x);
                    n_errors++;
                end
                if (o_data.job_y !== e.job_y) begin
                    $error("job_y: expected %0d, got %0d", e.job_y, o_data.job_y);
                    n_errors++;
                end
                if (o_data.last_result !== e.last_result) begin
                    $error("last_result: expected %0d, got %0d", e.last_result,
                           o_data.last_result);
                    n_errors++;
                end
            end
        end
    end

    // drive one beat and hold it until accepted
    task automatic send_beat(t_in_beat b);
        @(negedge i_clk);
        i_valid = 1'b1;
        i_data = b;
        do @(posedge i_clk); while (o_stall);
        predict_beat(b);
        if ($urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            i_data = t_in_beat'($urandom());
            repeat (gap_len() - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_tile(logic [21:0] x, logic signed [23:0] y,
                             logic [4:0] z, bit last);
        t_in_beat b;
        b = t_in_beat'({$urandom(), $urandom()});
        b.opcode = OP_TILE;
        b.tile_x = x;
        b.tile_y = y;
        b.zoom_level = z;
        b.last_of_frame = last;
        send_beat(b);
    endtask

    task automatic send_completion(logic [1:0] op, logic [3:0] s, logic [21:0] x,
                                   logic [21:0] y, logic [4:0] z);
        t_in_beat b;
        b = t_in_beat'({$urandom(), $urandom()});
        b.opcode = op;
        b.done_slot = s;
        b.tile_x = x;
        b.tile_y = {2'($urandom_range(0, 3)), y};
        b.zoom_level = z;
        b.last_of_frame = 1'($urandom_range(0, 1));
        send_beat(b);
    endtask

    // finish most busy fetches, mostly with success
    task automatic complete_fetches();
        for (int s = 0; s < CacheSlots; s++)
            if (slot_bsy[s] && $urandom_range(0, 4) != 0)
                send_completion($urandom_range(0, 3) != 0 ? OP_DONE : OP_FAIL,
                                s[3:0], fetch_x[s], fetch_y[s], fetch_z[s]);
    endtask

    task automatic test_directed();
        t_in_beat b;
        send_tile(22'd0, -24'sd1, 5'd0, 0);               // row above the world
        send_tile(22'd0, 24'sd0, 5'd0, 0);                // new job
        send_tile(22'd0, 24'sd0, 5'd0, 0);                // shares the job
        send_tile(22'h3FFFFF, 24'sh7FFFFF, 5'd0, 0);      // far below the world
        send_tile(22'h3FFFFF, -24'sd4194304, 5'd0, 0);
        send_tile(22'h3FFFFF, 24'sd4194303, 5'd31, 1);    // zoom above 22
        b = '0;
        b.opcode = OP_RSVD;                               // ignored opcode
        b.tile_x = 22'h3FFFFF;
        b.tile_y = -24'sd1;
        b.zoom_level = 5'd31;
        b.done_slot = 4'hF;
        b.last_of_frame = 1;
        send_beat(b);
        complete_fetches();
        for (int s = 0; s < CacheSlots; s++)
            if (slot_bsy[s])
                send_completion(OP_DONE, s[3:0], fetch_x[s], fetch_y[s], fetch_z[s]);
        // same tiles again: hits on the slots whose fetch succeeded
        send_tile(22'd0, 24'sd0, 5'd31, 0);
        send_tile(22'h3FFFFF, 24'sd4194303, 5'd31, 1);
        send_completion(OP_FAIL, 4'd15, 22'd0, 22'd0, 5'd0);
        send_completion(OP_DONE, 4'd7, 22'h2AAAAA, 22'h155555, 5'd22);
    endtask

    // more distinct tiles than slots and than list entries
    task automatic test_overflow();
        for (int i = 0; i < MaxFrameTiles + 2; i++)
            send_tile(22'(1000 + i), 24'(i), 5'd22, i == MaxFrameTiles + 1);
        complete_fetches();
        for (int i = 0; i < MaxFrameTiles; i++)
            send_tile(22'(2000 + i), 24'(i), 5'd21, i == MaxFrameTiles - 1);
        complete_fetches();
    endtask

    task automatic test_random(int n_items);
        logic [21:0] pool_x [8];
        int          pool_y [8];
        int          sent;
        int          len;
        int          rows;
        int          k;
        logic [4:0]  z;
        logic signed [23:0] y;
        logic [21:0] x;
        sent = 0;
        for (int i = 0; i < 8; i++) begin
            pool_x[i] = 22'($urandom());
            pool_y[i] = $urandom();
        end
        while (sent < n_items) begin
            case ($urandom_range(0, 5))
                0: z = 5'd0;
                1: z = 5'd22;
                2: z = 5'd31;
                3: z = 5'd3;
                default: z = 5'($urandom_range(0, 31));
            endcase
            rows = 1 << ((z > 22) ? 22 : z);
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 18) : $urandom_range(1, 6);
            for (int i = 0; i < len; i++) begin
                k = $urandom_range(0, 9);
                if (k < 7) begin
                    x = pool_x[k];
                    y = 24'(pool_y[k] & (rows - 1));
                end else begin
                    x = 22'($urandom());
                    y = (k == 9) ? 24'($urandom()) : 24'($urandom_range(0, rows - 1));
                end
                send_tile(x, y, z, i == len - 1);
                sent++;
                if ($urandom_range(0, 15) == 0) begin
                    send_completion(2'($urandom_range(1, 3)), 4'($urandom()),
                                    22'($urandom()), 22'($urandom()), 5'($urandom()));
                    sent++;
                end
            end
            complete_fetches();
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data = '0;
        i_stall = 1'b0;
        n_errors = 0;
        n_cycles = 0;
        stall_left = 0;
        list_n = 0;
        job_n = 0;
        for (int s = 0; s < CacheSlots; s++) begin
            tag_x[s] = '0; tag_y[s] = '0; tag_z[s] = '0;
            slot_ok[s] = 0; slot_bsy[s] = 0;
            fetch_x[s] = '0; fetch_y[s] = '0; fetch_z[s] = '0;
        end
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_overflow();
        test_random(40);

        @(negedge i_clk);
        i_valid = 1'b0;
        while (exp_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (n_errors == 0 && exp_results.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule

[filelist.f]
+incdir+src
src/tcsm_pkg.sv
src/tcsm_datapath.sv
src/tcsm_ctrl.sv
src/tile_cache_slot_manager_core.sv
test/tb_tile_cache_slot_manager_core.sv
